// ===== rtl/core/shp_pkg.sv =====
// ----------------------------------------------------------------------------
// Slope hillshade package
// Fixed-point constants, register indexes and reset values that the pixel
// unit and its channel boost stage share.
// ----------------------------------------------------------------------------
package shp_pkg;

  // Field widths.
  localparam int unsigned HGT_W  = 8;
  localparam int unsigned CHAN_W = 8;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_WATER_LEVEL     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRASS_LOW_LEVEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROCK_LEVEL      = 2'd2;

  localparam logic [HGT_W-1:0] WATER_LEVEL_RST     = 8'd64;
  localparam logic [HGT_W-1:0] GRASS_LOW_LEVEL_RST = 8'd110;
  localparam logic [HGT_W-1:0] ROCK_LEVEL_RST      = 8'd200;

  // Q16 constants: 1.0, 0.04, 0.25 and 1.4.
  localparam logic signed [25:0] Q_ONE   = 26'sd65536;
  localparam logic signed [25:0] Q_STEP  = 26'sd2621;
  localparam logic signed [25:0] Q_FLOOR = 26'sd16384;
  localparam logic signed [41:0] Q_SAT   = 42'sd91750;

  // Brightest channel value in Q16.
  localparam logic signed [26:0] CHAN_MAX_Q = 27'sd16711680;
  localparam logic [CHAN_W-1:0]  CHAN_MAX   = 8'd255;

  // Exact floor division by three for values below 2^26:
  // mean = (sum * ceil(2^27 / 3)) >> 27.
  localparam int unsigned      DIV3_SHIFT = 27;
  localparam logic [51:0]      DIV3_MULT  = 52'd44739243;

endpackage : shp_pkg

// ===== rtl/core/shp_boost.sv =====
// ----------------------------------------------------------------------------
// Slope hillshade channel boost
// Pushes one scaled channel away from the channel mean by 1.4, truncating
// toward zero, then clamps the result to 0..255 and drops the fraction.
// ----------------------------------------------------------------------------
module shp_boost (
  input  logic        clk_i,
  input  logic        en_i,     // load the product register
  input  logic [23:0] chan_i,   // scaled channel, Q16
  input  logic [23:0] mean_i,   // mean of the three scaled channels, Q16
  output logic [7:0]  chan_o    // clamped channel, integer part
);

  logic signed [24:0] diff;
  logic signed [41:0] prod_d, prod_q;
  logic [23:0]        mean_q;
  logic signed [41:0] biased;
  logic signed [25:0] delta;
  logic signed [26:0] boosted;

  // Distance from the mean times 1.4 in Q16.
  assign diff   = $signed({1'b0, chan_i}) - $signed({1'b0, mean_i});
  assign prod_d = 42'(diff) * shp_pkg::Q_SAT;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      mean_q <= mean_i;
    end
  end

  // Drop the fraction toward zero: negative products are biased first.
  assign biased  = prod_q + (prod_q[41] ? 42'sd65535 : 42'sd0);
  assign delta   = biased[41:16];
  assign boosted = 27'(delta) + $signed({3'b000, mean_q});

  // Clamp to the channel range and keep the integer part.
  always_comb begin
    priority if (boosted[26]) begin
      chan_o = '0;
    end else if (boosted > shp_pkg::CHAN_MAX_Q) begin
      chan_o = shp_pkg::CHAN_MAX;
    end else begin
      chan_o = boosted[23:16];
    end
  end

endmodule : shp_boost

// ===== rtl/core/slope_hillshade_pixel_unit.sv =====
// ----------------------------------------------------------------------------
// Slope hillshade pixel unit
// Shades one terrain pixel from the height steps to its right and lower
// neighbors: slopes facing away darken and gain saturation, slopes facing
// the light brighten. Border pixels and pixels outside the height bands
// pass through.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake             | Contents
//  ---------+-----------+-----------------------+-------------------------------
//  s_axis   | in        | tvalid / tready       | heights, border flag, color
//  m_axis   | out       | tvalid / tready       | shaded color
//  cfg      | in        | cfg_valid / cfg_ready | band level register writes
//
//  One item per cycle sustained while the output is not stalled. An item
//  passes through the stages in order and waits in the output register
//  until it is taken. The pipeline has seven register stages, each with its
//  own valid bit; a stage loads whenever it is empty or the stage after it
//  moves, so bubbles close up and a stalled output holds without loss.
//  Reset clears the valid bits and loads the default band levels.
//  Configuration writes are always taken.
//
// ----------------------------------------------------------------------------
module slope_hillshade_pixel_unit (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Pixel input.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] height_here, [15:8] height_right, [23:16] height_below,
  // [31:24] red_in, [39:32] green_in, [47:40] blue_in
  input  logic [47:0] s_axis_tdata,
  // [0] border_pixel
  input  logic [0:0]  s_axis_tuser,

  // Shaded pixel output.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] red_out, [15:8] green_out, [23:16] blue_out
  output logic [23:0] m_axis_tdata,

  // Configuration writes.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  localparam int unsigned NumStages = 7;

  // Band level registers.
  logic [7:0] water_q, grass_q, rock_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      water_q <= shp_pkg::WATER_LEVEL_RST;
      grass_q <= shp_pkg::GRASS_LOW_LEVEL_RST;
      rock_q  <= shp_pkg::ROCK_LEVEL_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        shp_pkg::CFG_WATER_LEVEL:     water_q <= cfg_data_i;
        shp_pkg::CFG_GRASS_LOW_LEVEL: grass_q <= cfg_data_i;
        shp_pkg::CFG_ROCK_LEVEL:      rock_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline flow control: a stage loads when it is empty or drains.
  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] vld_in;
  logic [NumStages:0]   rdy;
  logic [NumStages-1:0] en;

  always_comb begin
    // Ready ripples back from the output side.
    rdy[NumStages] = m_axis_tready;
    for (int k = NumStages - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    vld_in[0] = s_axis_tvalid;
    for (int k = 1; k < NumStages; k++) begin
      vld_in[k] = vld_q[k-1];
    end
    en = rdy[NumStages-1:0] & vld_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld_q[NumStages-1];

  // Stage 1: band test and light value, trunc((dr + dd) * 2.5).
  logic [7:0]         hgt, hgt_r, hgt_b;
  logic               in_band, shade_d;
  logic signed [10:0] step_sum;
  logic signed [12:0] step_x5;
  logic signed [12:0] step_x5_b;
  logic signed [11:0] light_d;

  assign hgt   = s_axis_tdata[7:0];
  assign hgt_r = s_axis_tdata[15:8];
  assign hgt_b = s_axis_tdata[23:16];

  assign in_band  = ((hgt < grass_q) && (hgt > water_q)) || (hgt >= rock_q);
  assign shade_d  = !s_axis_tuser[0] && in_band;
  assign step_sum = $signed({3'b000, hgt_r}) + $signed({3'b000, hgt_b})
                  - $signed({2'b00, hgt, 1'b0});
  assign step_x5   = (13'(step_sum) <<< 2) + 13'(step_sum);
  assign step_x5_b = step_x5 + (step_x5[12] ? 13'sd1 : 13'sd0);
  assign light_d   = step_x5_b[12:1];

  logic               shade1_q;
  logic signed [11:0] light1_q;
  logic [23:0]        col1_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      shade1_q <= shade_d;
      light1_q <= light_d;
      col1_q   <= s_axis_tdata[47:24];
    end
  end

  // Stage 2: darkening factor for shadow, saturating add for light.
  logic               neg_d;
  logic signed [25:0] fac_raw;
  logic [15:0]        fac_d;
  logic [23:0]        col2_d;
  logic [10:0]        lit_sum;

  assign neg_d   = shade1_q && light1_q[11];
  assign fac_raw = shp_pkg::Q_ONE + 26'(light1_q) * shp_pkg::Q_STEP;
  assign fac_d   = (fac_raw < shp_pkg::Q_FLOOR) ? 16'(shp_pkg::Q_FLOOR) : fac_raw[15:0];

  always_comb begin
    lit_sum = '0;
    for (int c = 0; c < 3; c++) begin
      lit_sum = {3'b000, col1_q[8*c +: 8]} + 11'(light1_q[10:0]);
      if (shade1_q && !light1_q[11]) begin
        col2_d[8*c +: 8] = (lit_sum > 11'd255) ? shp_pkg::CHAN_MAX : lit_sum[7:0];
      end else begin
        col2_d[8*c +: 8] = col1_q[8*c +: 8];
      end
    end
  end

  logic        neg2_q;
  logic [15:0] fac2_q;
  logic [23:0] col2_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      neg2_q <= neg_d;
      fac2_q <= fac_d;
      col2_q <= col2_d;
    end
  end

  // Stage 3: scale each channel by the factor.
  logic [23:0] sc3_q [3];
  logic        neg3_q;
  logic [23:0] col3_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int c = 0; c < 3; c++) begin
        sc3_q[c] <= 24'(col2_q[8*c +: 8]) * 24'(fac2_q);
      end
      neg3_q <= neg2_q;
      col3_q <= col2_q;
    end
  end

  // Stage 4: sum of the scaled channels.
  logic [25:0] sum4_q;
  logic [23:0] sc4_q [3];
  logic        neg4_q;
  logic [23:0] col4_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      sum4_q <= 26'(sc3_q[0]) + 26'(sc3_q[1]) + 26'(sc3_q[2]);
      sc4_q  <= sc3_q;
      neg4_q <= neg3_q;
      col4_q <= col3_q;
    end
  end

  // Stage 5: mean by reciprocal multiplication.
  logic [51:0] mean_prod;
  logic [23:0] mean5_q;
  logic [23:0] sc5_q [3];
  logic        neg5_q;
  logic [23:0] col5_q;

  assign mean_prod = 52'(sum4_q) * shp_pkg::DIV3_MULT;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      mean5_q <= mean_prod[shp_pkg::DIV3_SHIFT +: 24];
      sc5_q   <= sc4_q;
      neg5_q  <= neg4_q;
      col5_q  <= col4_q;
    end
  end

  // Stage 6: saturation boost, one unit per channel.
  logic [7:0]  boost_chan [3];
  logic        neg6_q;
  logic [23:0] col6_q;

  for (genvar c = 0; c < 3; c++) begin : g_boost
    shp_boost u_boost (
      .clk_i  (clk_i),
      .en_i   (en[5]),
      .chan_i (sc5_q[c]),
      .mean_i (mean5_q),
      .chan_o (boost_chan[c])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      neg6_q <= neg5_q;
      col6_q <= col5_q;
    end
  end

  // Stage 7: output register, shadowed or passed color.
  logic [23:0] out_d, out_q;

  assign out_d = neg6_q ? {boost_chan[2], boost_chan[1], boost_chan[0]} : col6_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tdata = out_q;

endmodule : slope_hillshade_pixel_unit

// ===== bench/slope_hillshade_pixel_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slope hillshade pixel unit testbench
// Streams terrain pixels through the unit under several band level settings
// and checks every shaded color against a Q16 model of the shading kept in
// the bench: band selection, brightening with saturation, and darkening with
// the saturation boost and clamping. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module slope_hillshade_pixel_unit_tb;

  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned MAX_REPORTS  = 60;
  // Index that no band level register answers to.
  localparam logic [shp_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  // Input item as packed into tdata, lowest field in the lowest bits.
  typedef struct packed {
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
    logic [7:0] height_below;
    logic [7:0] height_right;
    logic [7:0] height_here;
  } pixel_data_t;

  typedef struct packed {
    logic        border;
    pixel_data_t data;
  } pixel_t;

  // Result item as packed into tdata.
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } color_t;

  typedef enum logic [1:0] {SHADE_NONE, SHADE_LIGHTEN, SHADE_DARKEN} shade_kind_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [7:0]  cfg_data_i = '0;

  // Band levels as the unit should hold them.
  logic [7:0] water_lvl = shp_pkg::WATER_LEVEL_RST;
  logic [7:0] grass_lvl = shp_pkg::GRASS_LOW_LEVEL_RST;
  logic [7:0] rock_lvl  = shp_pkg::ROCK_LEVEL_RST;

  pixel_t      pixel_q[$];
  color_t      shaded_q[$];
  pixel_t      pixel_cur;
  pixel_t      pixel_next;
  shade_kind_e kind_now;
  color_t      exp_col;
  color_t      got_col;

  int pixels_queued = 0;
  int pixels_done   = 0;
  int src_gap       = 0;
  int sink_stall    = 0;
  int stall_next;
  int mismatch_cnt  = 0;
  int settings_cnt  = 1;
  int pass_cnt      = 0;
  int lighten_cnt   = 0;
  int darken_cnt    = 0;
  bit src_gaps_on   = 1'b1;
  bit sink_stalls_on = 1'b1;

  slope_hillshade_pixel_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Saturation boost of one Q16 channel around the mean, clamped to 0..255.
  function automatic logic [7:0] boost_chan(input longint c, input longint mean);
    longint d;
    longint v;
    d = ((c - mean) * longint'(shp_pkg::Q_SAT)) / longint'(shp_pkg::Q_ONE);
    v = mean + d;
    if (v < 0) v = 0;
    if (v > longint'(shp_pkg::CHAN_MAX_Q)) v = longint'(shp_pkg::CHAN_MAX_Q);
    return 8'(v / longint'(shp_pkg::Q_ONE));
  endfunction

  function automatic logic [7:0] lighten_chan(input logic [7:0] c, input int light);
    int v;
    v = int'(c) + light;
    return (v > int'(shp_pkg::CHAN_MAX)) ? shp_pkg::CHAN_MAX : 8'(v);
  endfunction

  // Expected color of one pixel under the current band levels.
  function automatic color_t shade_pixel(input pixel_t px, output shade_kind_e kind);
    int     h;
    int     hr;
    int     hd;
    int     light;
    longint f;
    longint cr;
    longint cg;
    longint cb;
    longint mean;
    color_t col;
    col.red   = px.data.red_in;
    col.green = px.data.green_in;
    col.blue  = px.data.blue_in;
    kind = SHADE_NONE;
    h  = px.data.height_here;
    hr = px.data.height_right;
    hd = px.data.height_below;
    if (!px.border &&
        ((h < int'(grass_lvl) && h > int'(water_lvl)) || h >= int'(rock_lvl))) begin
      // Integer division truncates toward zero, as the light value needs.
      light = ((hr - h) + (hd - h)) * 5 / 2;
      if (light < 0) begin
        kind = SHADE_DARKEN;
        f = longint'(shp_pkg::Q_ONE) + longint'(light) * longint'(shp_pkg::Q_STEP);
        if (f < longint'(shp_pkg::Q_FLOOR)) f = longint'(shp_pkg::Q_FLOOR);
        cr = longint'(px.data.red_in) * f;
        cg = longint'(px.data.green_in) * f;
        cb = longint'(px.data.blue_in) * f;
        mean = (cr + cg + cb) / 3;
        col.red   = boost_chan(cr, mean);
        col.green = boost_chan(cg, mean);
        col.blue  = boost_chan(cb, mean);
      end else begin
        kind = SHADE_LIGHTEN;
        col.red   = lighten_chan(px.data.red_in, light);
        col.green = lighten_chan(px.data.green_in, light);
        col.blue  = lighten_chan(px.data.blue_in, light);
      end
    end
    return col;
  endfunction

  // Pixel source: one item at a time from the pending queue, with a random
  // gap after each one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        shaded_q.push_back(shade_pixel(pixel_cur, kind_now));
        case (kind_now)
          SHADE_LIGHTEN: lighten_cnt++;
          SHADE_DARKEN:  darken_cnt++;
          default:       pass_cnt++;
        endcase
        pixels_done <= pixels_done + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          s_axis_tvalid <= 1'b0;
          src_gap <= src_gap - 1;
        end else if (pixel_q.size() != 0) begin
          pixel_next = pixel_q.pop_front();
          pixel_cur <= pixel_next;
          s_axis_tdata <= pixel_next.data;
          s_axis_tuser <= pixel_next.border;
          s_axis_tvalid <= 1'b1;
          src_gap <= src_gaps_on ? $urandom_range(0, 11) : 0;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic report_field(input string name, input logic [7:0] expv,
                              input logic [7:0] gotv);
    if (expv != gotv) begin
      mismatch_cnt++;
      if (mismatch_cnt <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, gotv);
    end
  endtask

  // Color sink: checks each shaded item and stalls at random after it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_stall <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_col = m_axis_tdata;
        if (shaded_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected item, expected none, actual %h", $time, got_col);
        end else begin
          exp_col = shaded_q.pop_front();
          report_field("red_out", exp_col.red, got_col.red);
          report_field("green_out", exp_col.green, got_col.green);
          report_field("blue_out", exp_col.blue, got_col.blue);
        end
        stall_next = sink_stalls_on ? $urandom_range(0, 11) : 0;
      end else begin
        stall_next = (sink_stall > 0) ? sink_stall - 1 : 0;
      end
      sink_stall <= stall_next;
      m_axis_tready <= (stall_next == 0);
    end
  end

  // One band level write; the unit must be idle.
  task automatic write_level(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      shp_pkg::CFG_WATER_LEVEL:     water_lvl = val;
      shp_pkg::CFG_GRASS_LOW_LEVEL: grass_lvl = val;
      shp_pkg::CFG_ROCK_LEVEL:      rock_lvl  = val;
      default: ;
    endcase
  endtask

  task automatic queue_pixel(input logic [7:0] h, input logic [7:0] hr, input logic [7:0] hd,
                             input logic border, input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b);
    pixel_t px;
    px.border = border;
    px.data.height_here  = h;
    px.data.height_right = hr;
    px.data.height_below = hd;
    px.data.red_in   = r;
    px.data.green_in = g;
    px.data.blue_in  = b;
    pixel_q.push_back(px);
    pixels_queued++;
  endtask

  // Neighbor height within a moderate step of the pixel's own.
  function automatic logic [7:0] near_height(input int base);
    int v;
    v = base + $urandom_range(0, 80) - 40;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  function automatic logic [7:0] random_chan();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 8'd255 : 8'd0;
    return 8'($urandom_range(0, 255));
  endfunction

  // Waits until every queued pixel is in and every result has come back.
  task automatic settle();
    while (pixels_done != pixels_queued || shaded_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Random pixels, mostly aimed at the shaded bands, then a full drain.
  task automatic run_random(input int n);
    int h;
    src_gaps_on    = ($urandom_range(0, 3) != 0);
    sink_stalls_on = ($urandom_range(0, 3) != 0);
    for (int i = 0; i < n; i++) begin
      h = $urandom_range(0, 255);
      if ($urandom_range(0, 1) && int'(grass_lvl) > int'(water_lvl) + 1)
        h = $urandom_range(int'(water_lvl) + 1, int'(grass_lvl) - 1);
      else if ($urandom_range(0, 1))
        h = $urandom_range(int'(rock_lvl), 255);
      if ($urandom_range(0, 3) == 0)
        queue_pixel(8'(h), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    ($urandom_range(0, 7) == 0), random_chan(), random_chan(), random_chan());
      else
        queue_pixel(8'(h), near_height(h), near_height(h), ($urandom_range(0, 7) == 0),
                    random_chan(), random_chan(), random_chan());
    end
    settle();
  endtask

  initial begin
    int lvl;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed pixels under the reset band levels.
    queue_pixel(8'd80, 8'd80, 8'd80, 1'b0, 8'd10, 8'd20, 8'd30);      // flat, zero light
    queue_pixel(8'd80, 8'd81, 8'd80, 1'b0, 8'd10, 8'd20, 8'd30);      // smallest rise
    queue_pixel(8'd80, 8'd79, 8'd80, 1'b0, 8'd100, 8'd150, 8'd200);   // smallest fall
    queue_pixel(8'd255, 8'd0, 8'd0, 1'b0, 8'd255, 8'd128, 8'd0);      // factor at floor
    queue_pixel(8'd200, 8'd255, 8'd255, 1'b0, 8'd255, 8'd0, 8'd128);  // bright saturation
    queue_pixel(8'd0, 8'd255, 8'd255, 1'b0, 8'd40, 8'd50, 8'd60);     // below water
    queue_pixel(8'd64, 8'd0, 8'd0, 1'b0, 8'd40, 8'd50, 8'd60);        // at water level
    queue_pixel(8'd65, 8'd0, 8'd0, 1'b0, 8'd200, 8'd100, 8'd50);      // lowest banded height
    queue_pixel(8'd109, 8'd100, 8'd105, 1'b0, 8'd255, 8'd255, 8'd255);
    queue_pixel(8'd110, 8'd90, 8'd90, 1'b0, 8'd40, 8'd50, 8'd60);     // at grass level
    queue_pixel(8'd199, 8'd150, 8'd150, 1'b0, 8'd40, 8'd50, 8'd60);   // just under rock
    queue_pixel(8'd200, 8'd198, 8'd199, 1'b0, 8'd255, 8'd0, 8'd0);    // boost clamps low
    queue_pixel(8'd150, 8'd80, 8'd80, 1'b1, 8'd1, 8'd2, 8'd3);
    queue_pixel(8'd90, 8'd0, 8'd0, 1'b1, 8'd255, 8'd255, 8'd255);     // border in band
    queue_pixel(8'd230, 8'd229, 8'd230, 1'b0, 8'd0, 8'd0, 8'd0);
    queue_pixel(8'd230, 8'd229, 8'd230, 1'b0, 8'd255, 8'd255, 8'd255);
    queue_pixel(8'd100, 8'd101, 8'd100, 1'b0, 8'd250, 8'd254, 8'd255);
    queue_pixel(8'd255, 8'd255, 8'd255, 1'b0, 8'd1, 8'd2, 8'd3);
    queue_pixel(8'd240, 8'd235, 8'd0, 1'b0, 8'd0, 8'd255, 8'd0);
    queue_pixel(8'd70, 8'd255, 8'd0, 1'b0, 8'd12, 8'd34, 8'd56);
    queue_pixel(8'd90, 8'd88, 8'd87, 1'b0, 8'd0, 8'd255, 8'd255);     // boost clamps low
    settle();
    run_random(200);

    // Widest low band, rock only at the top height.
    write_level(shp_pkg::CFG_WATER_LEVEL, 8'd0);
    write_level(shp_pkg::CFG_GRASS_LOW_LEVEL, 8'd255);
    write_level(shp_pkg::CFG_ROCK_LEVEL, 8'd255);
    settings_cnt++;
    run_random(200);

    // Empty low band, every height at or above rock.
    write_level(shp_pkg::CFG_WATER_LEVEL, 8'd255);
    write_level(shp_pkg::CFG_GRASS_LOW_LEVEL, 8'd0);
    write_level(shp_pkg::CFG_ROCK_LEVEL, 8'd0);
    settings_cnt++;
    run_random(150);

    // Inverted low band; the write to the spare index must change nothing.
    write_level(shp_pkg::CFG_WATER_LEVEL, 8'd200);
    write_level(shp_pkg::CFG_GRASS_LOW_LEVEL, 8'd100);
    write_level(shp_pkg::CFG_ROCK_LEVEL, 8'd255);
    write_level(CFG_UNUSED_IDX, 8'h5a);
    settings_cnt++;
    run_random(150);

    for (int p = 0; p < 4; p++) begin
      if (p < 2) begin
        lvl = $urandom_range(0, 180);
        write_level(shp_pkg::CFG_WATER_LEVEL, 8'(lvl));
        write_level(shp_pkg::CFG_GRASS_LOW_LEVEL, 8'(lvl + $urandom_range(2, 75)));
      end else begin
        write_level(shp_pkg::CFG_WATER_LEVEL, 8'($urandom_range(0, 255)));
        write_level(shp_pkg::CFG_GRASS_LOW_LEVEL, 8'($urandom_range(0, 255)));
      end
      write_level(shp_pkg::CFG_ROCK_LEVEL, 8'($urandom_range(0, 255)));
      settings_cnt++;
      run_random(150);
    end

    write_level(shp_pkg::CFG_WATER_LEVEL, shp_pkg::WATER_LEVEL_RST);
    write_level(shp_pkg::CFG_GRASS_LOW_LEVEL, shp_pkg::GRASS_LOW_LEVEL_RST);
    write_level(shp_pkg::CFG_ROCK_LEVEL, shp_pkg::ROCK_LEVEL_RST);
    settings_cnt++;
    run_random(100);

    $display("Shaded %0d pixels under %0d band level settings.", pixels_done, settings_cnt);
    $display("Passed through %0d, brightened %0d, darkened %0d; %0d mismatches.",
             pass_cnt, lighten_cnt, darken_cnt, mismatch_cnt);
    if (mismatch_cnt == 0 && shaded_q.size() == 0)
      $display("PASS slope_hillshade_pixel_unit");
    else
      $display("FAIL slope_hillshade_pixel_unit");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #5_000_000;
    $display("FAIL slope_hillshade_pixel_unit");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/shp_pkg.sv
rtl/core/shp_boost.sv
rtl/core/slope_hillshade_pixel_unit.sv
bench/slope_hillshade_pixel_unit_tb.sv
